[rtl/mcs_pkg.sv]
// Shared types and constants for the mesh configuration element scanner.
// No dependencies; every other file of the block imports this package.
package mcs_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BUF_LEN_W  = 16;
    localparam int unsigned OFFSET_W   = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] TARGET_ID_RST = 8'd113;
    localparam logic [BYTE_W-1:0] MAX_LEN_RST   = 8'd32;

    // register index, taken from address bit 2
    localparam logic REG_TARGET_ID = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    // body offsets counted from the first byte after the matched length byte
    localparam logic [OFFSET_W-1:0] OFF_PATH_SEL    = 4'd0;
    localparam logic [OFFSET_W-1:0] OFF_PATH_METRIC = 4'd1;
    localparam logic [OFFSET_W-1:0] OFF_SYNC        = 4'd3;
    localparam logic [OFFSET_W-1:0] OFF_AUTH        = 4'd4;
    localparam logic [OFFSET_W-1:0] LAST_OFFSET     = 4'd10;

    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_ID   = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] target_id;
        logic [BYTE_W-1:0] max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]    ie_byte;
        logic                 first_byte;
        logic                 last_byte;
        logic [BUF_LEN_W-1:0] buffer_length;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] path_selection;
        logic [BYTE_W-1:0] path_metric;
        logic [BYTE_W-1:0] sync_method;
        logic [BYTE_W-1:0] auth_protocol;
        logic [BYTE_W-1:0] congestion_control;
    } t_fields;

    // handshake between the input register and the parser
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

[rtl/mcs_if.sv]
// Valid/ready channel interfaces for the scanner's byte input and result output.
// Depends on mcs_pkg for field widths.
interface mcs_in_if import mcs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [BYTE_W-1:0]    ie_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic [BUF_LEN_W-1:0] buffer_length;

    modport source (output valid, ie_byte, first_byte, last_byte, buffer_length,
                    input ready);
    modport sink   (input valid, ie_byte, first_byte, last_byte, buffer_length,
                    output ready);
endinterface

interface mcs_out_if import mcs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic              short_element;
    logic [BYTE_W-1:0] path_selection;
    logic [BYTE_W-1:0] path_metric;
    logic [BYTE_W-1:0] sync_method;
    logic [BYTE_W-1:0] auth_protocol;
    logic [BYTE_W-1:0] congestion_control;

    modport source (output valid, found, short_element, path_selection, path_metric,
                    sync_method, auth_protocol, congestion_control,
                    input ready);
    modport sink   (input valid, found, short_element, path_selection, path_metric,
                    sync_method, auth_protocol, congestion_control,
                    output ready);
endinterface

[rtl/mesh_config_element_scanner.sv]
// Top level of the mesh configuration element scanner.
// Depends on mcs_pkg, mcs_if, mcs_cfg_regs, mcs_in_stage and mcs_parser.
//
//   channel   direction  handshake             payload
//   i_in      in         valid/ready           ie_byte, first_byte, last_byte, buffer_length
//   o_out     out        valid/ready           found, short_element, five captured bytes
//   apb       in         psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
// One byte item per cycle unless a held result stalls intake; a result is registered
// in the parser's result register on o_out after its byte passes the input register.
// Synchronous active-low reset clears the scan state to awaiting a first byte.
// A held result stalls intake whether or not the next byte emits; ready drops
// only while o_out is valid and not taken.
module mesh_config_element_scanner import mcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mcs_in_if.sink                i_in,
    mcs_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       cfg;
    t_stage_ctl stage_ctl;
    t_item      item;
    logic       advance;

    mcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mcs_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_ctl     (stage_ctl),
        .o_item    (item)
    );

    mcs_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_ctl     (stage_ctl),
        .i_item    (item),
        .o_advance (advance),
        .o_out     (o_out)
    );

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a blocked result");

    a_short_implies_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.short_element) |-> o_out.found)
        else $error("short element flagged on a not-found result");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |->
            (o_out.path_selection == '0 && o_out.path_metric == '0 &&
             o_out.sync_method == '0 && o_out.auth_protocol == '0 &&
             o_out.congestion_control == '0))
        else $error("not-found result carries nonzero fields");

endmodule

[rtl/mcs_cfg_regs.sv]
// APB-style configuration registers: target element id and maximum length.
// Depends on mcs_pkg.
module mcs_cfg_regs import mcs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [BYTE_W-1:0] r_target_id;
    logic [BYTE_W-1:0] r_max_len;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id <= TARGET_ID_RST;
            r_max_len   <= MAX_LEN_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TARGET_ID: r_target_id <= pwdata[BYTE_W-1:0];
                REG_MAX_LEN:   r_max_len   <= pwdata[BYTE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TARGET_ID: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_target_id};
            REG_MAX_LEN:   prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_max_len};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.target_id = r_target_id;
    assign o_cfg.max_len   = r_max_len;

endmodule

[rtl/mcs_in_stage.sv]
// Input register of the scanner: captures one byte item per cycle from the channel while empty or advancing.
// Depends on mcs_pkg and mcs_in_if.
module mcs_in_stage import mcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcs_in_if.sink     i_in,
    input  logic       i_advance,
    output t_stage_ctl o_ctl,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.ie_byte       <= i_in.ie_byte;
            r_item.first_byte    <= i_in.first_byte;
            r_item.last_byte     <= i_in.last_byte;
            r_item.buffer_length <= i_in.buffer_length;
        end
    end

    assign o_ctl.valid   = r_valid;
    assign o_ctl.advance = i_advance;
    assign o_item        = r_item;

endmodule

[rtl/mcs_parser.sv]
// Element parser: per-byte state update, field capture and result register.
// Depends on mcs_pkg and mcs_out_if.
module mcs_parser import mcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_stage_ctl i_ctl,
    input  t_item      i_item,
    output logic       o_advance,
    mcs_out_if.source  o_out
);

    logic [BUF_LEN_W-1:0] r_rem,    n_rem;
    t_phase               r_phase,  n_phase;
    logic                 r_capt,   n_capt;
    logic [BYTE_W-1:0]    r_cur_id, n_cur_id;
    logic [BYTE_W-1:0]    r_body,   n_body;
    logic [OFFSET_W-1:0]  r_off,    n_off;
    t_fields              r_cf,     n_cf;

    logic    r_res_valid;
    logic    r_found;
    logic    r_short;
    t_fields r_res;

    logic    proc;
    logic    emit;
    logic    e_found;
    logic    e_short;

    assign o_advance = !r_res_valid || o_out.ready;
    assign proc      = i_ctl.valid && o_advance;

    always_comb begin
        logic stop;
        logic [BYTE_W-1:0] b;
        b        = i_item.ie_byte;
        stop     = 1'b0;
        emit     = 1'b0;
        e_found  = 1'b0;
        e_short  = 1'b0;
        n_rem    = r_rem;
        n_phase  = r_phase;
        n_capt   = r_capt;
        n_cur_id = r_cur_id;
        n_body   = r_body;
        n_off    = r_off;
        n_cf     = r_cf;

        if (i_item.first_byte) begin
            n_rem    = i_item.buffer_length;
            n_phase  = PH_ID;
            n_capt   = 1'b0;
            n_cur_id = '0;
            n_body   = '0;
            n_off    = '0;
            n_cf     = '0;
        end

        if (n_phase != PH_DONE) begin
            unique case (n_phase)
                PH_ID: begin
                    n_cur_id = b;
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    // element must fit: length plus the length byte within the remaining bytes
                    if (({{(BUF_LEN_W-BYTE_W){1'b0}}, b} + BUF_LEN_W'(1)) > n_rem) begin
                        n_phase = PH_DONE;
                        emit    = 1'b1;
                        stop    = 1'b1;
                    end else if (n_cur_id == i_cfg.target_id && b != '0
                                 && b <= i_cfg.max_len) begin
                        n_capt  = 1'b1;
                        n_off   = '0;
                        n_cf    = '0;
                        n_phase = PH_BODY;
                    end else begin
                        n_body  = b;
                        n_phase = (b == '0) ? PH_ID : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (n_capt) begin
                        case (n_off)
                            OFF_PATH_SEL:    n_cf.path_selection     = b;
                            OFF_PATH_METRIC: n_cf.path_metric        = b;
                            OFF_SYNC:        n_cf.sync_method        = b;
                            OFF_AUTH:        n_cf.auth_protocol      = b;
                            LAST_OFFSET:     n_cf.congestion_control = b;
                            default:         ;
                        endcase
                        if (n_off >= LAST_OFFSET) begin
                            n_capt  = 1'b0;
                            n_phase = PH_DONE;
                            emit    = 1'b1;
                            e_found = 1'b1;
                            stop    = 1'b1;
                        end else begin
                            n_off = n_off + OFFSET_W'(1);
                        end
                    end else begin
                        if (n_body != '0) begin
                            n_body = n_body - BYTE_W'(1);
                        end
                        if (n_body == '0) begin
                            n_phase = PH_ID;
                        end
                    end
                end
                default: ;
            endcase

            if (!stop) begin
                if (n_rem != '0) begin
                    n_rem = n_rem - BUF_LEN_W'(1);
                end
                // buffer end: report a partial capture as short, else a not-found result
                if (i_item.last_byte || n_rem == '0) begin
                    emit    = 1'b1;
                    e_found = n_capt;
                    e_short = n_capt;
                    n_capt  = 1'b0;
                    n_phase = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_phase     <= PH_DONE;
            r_capt      <= 1'b0;
            r_cur_id    <= '0;
            r_body      <= '0;
            r_off       <= '0;
            r_cf        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (proc) begin
                r_rem    <= n_rem;
                r_phase  <= n_phase;
                r_capt   <= n_capt;
                r_cur_id <= n_cur_id;
                r_body   <= n_body;
                r_off    <= n_off;
                r_cf     <= n_cf;
            end
            if (o_advance) begin
                r_res_valid <= proc && emit;
            end
        end
    end

    // result payload; not-found results carry zero fields
    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_found <= e_found;
            r_short <= e_short;
            r_res   <= e_found ? n_cf : '0;
        end
    end

    assign o_out.valid              = r_res_valid;
    assign o_out.found              = r_found;
    assign o_out.short_element      = r_short;
    assign o_out.path_selection     = r_res.path_selection;
    assign o_out.path_metric        = r_res.path_metric;
    assign o_out.sync_method        = r_res.sync_method;
    assign o_out.auth_protocol      = r_res.auth_protocol;
    assign o_out.congestion_control = r_res.congestion_control;

endmodule
